// ===== hdl/srv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srv_pkg
// Shared types and constants for the soil reading validator: word formats
// of both channels, range-check bounds and reset values of the held state.
// ----------------------------------------------------------------------------
package srv_pkg;

  // Input word: one poll result from the sensor
  typedef struct packed {
    logic        read_ok;
    logic [15:0] moisture_raw;
    logic [15:0] soil_temp_raw;
    logic [15:0] conductivity_raw;
    logic [15:0] acidity_raw;
    logic [15:0] nitrogen_raw;
    logic [15:0] phosphorus_raw;
    logic [15:0] potassium_raw;
  } in_word_t;

  // Output word: held readings and health / counter status
  typedef struct packed {
    logic        accepted;
    logic [15:0] moisture_out;
    logic [15:0] soil_temp_out;
    logic [15:0] conductivity_out;
    logic [15:0] acidity_out;
    logic [15:0] nitrogen_out;
    logic [15:0] phosphorus_out;
    logic [15:0] potassium_out;
    logic        healthy;
    logic [7:0]  run_errors;
    logic [31:0] poll_count;
    logic [31:0] fail_count;
  } out_word_t;

  // Check result handed from the range checker to the state tracker
  typedef struct packed {
    logic take;
  } check_t;

  // Range bounds in raw sensor units
  localparam logic [15:0] MOISTURE_MAX     = 16'd1000;
  localparam logic [15:0] SOIL_TEMP_MAX    = 16'd600;
  localparam logic [15:0] CONDUCTIVITY_MAX = 16'd10000;
  localparam logic [15:0] ACIDITY_MIN      = 16'd300;
  localparam logic [15:0] ACIDITY_MAX      = 16'd1000;

  // Reset values
  localparam logic [7:0]  ERROR_LIMIT_RESET  = 8'd5;
  localparam logic [15:0] MOISTURE_RESET     = 16'd300;
  localparam logic [15:0] SOIL_TEMP_RESET    = 16'd200;
  localparam logic [15:0] CONDUCTIVITY_RESET = 16'd1500;
  localparam logic [15:0] ACIDITY_RESET      = 16'd650;
  localparam logic [15:0] NUTRIENT_RESET     = 16'd0;

  // Counter saturation points
  localparam logic [7:0]  RUN_ERRORS_MAX = 8'hFF;
  localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

endpackage : srv_pkg
`default_nettype wire

// ===== hdl/srv_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srv_check
// Range check of one poll result: transfer flag plus the four bounded
// readings. Pure combinational.
// ----------------------------------------------------------------------------
module srv_check (
  input  wire srv_pkg::in_word_t word,
  output srv_pkg::check_t        check
);

  logic moisture_ok;
  logic temp_ok;
  logic cond_ok;
  logic acid_ok;

  // Raw words are unsigned, so only the acidity has a lower bound
  always_comb begin
    moisture_ok = (word.moisture_raw <= srv_pkg::MOISTURE_MAX);
    temp_ok     = (word.soil_temp_raw <= srv_pkg::SOIL_TEMP_MAX);
    cond_ok     = (word.conductivity_raw <= srv_pkg::CONDUCTIVITY_MAX);
    acid_ok     = (word.acidity_raw >= srv_pkg::ACIDITY_MIN) &&
                  (word.acidity_raw <= srv_pkg::ACIDITY_MAX);
    check.take  = word.read_ok && moisture_ok && temp_ok && cond_ok && acid_ok;
  end

endmodule : srv_check
`default_nettype wire

// ===== hdl/srv_track.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srv_track
// Held readings, health flag and saturating poll/fail counters. Computes
// the post-update status for the word in the input register and commits
// it when that word moves on to the output register.
// ----------------------------------------------------------------------------
module srv_track (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    update,
  input  wire srv_pkg::in_word_t word,
  input  wire srv_pkg::check_t   check,
  input  wire [7:0]              error_limit,
  output srv_pkg::out_word_t     result
);

  logic [15:0] held_moisture;
  logic [15:0] held_soil_temp;
  logic [15:0] held_conductivity;
  logic [15:0] held_acidity;
  logic [15:0] held_nitrogen;
  logic [15:0] held_phosphorus;
  logic [15:0] held_potassium;
  logic        health_flag;
  logic [7:0]  consecutive_fails;
  logic [31:0] total_polls;
  logic [31:0] total_fails;

  logic [7:0]  consecutive_fails_next;
  logic        health_flag_next;
  logic [31:0] total_polls_next;
  logic [31:0] total_fails_next;

  // Counter and health update
  always_comb begin
    total_polls_next = (total_polls == srv_pkg::COUNT_MAX) ?
                       total_polls : total_polls + 32'd1;
    if (check.take) begin
      consecutive_fails_next = '0;
      total_fails_next       = total_fails;
      health_flag_next       = 1'b1;
    end else begin
      consecutive_fails_next = (consecutive_fails == srv_pkg::RUN_ERRORS_MAX) ?
                               consecutive_fails : consecutive_fails + 8'd1;
      total_fails_next       = (total_fails == srv_pkg::COUNT_MAX) ?
                               total_fails : total_fails + 32'd1;
      // failures only ever clear health
      health_flag_next       = health_flag &&
                               !(consecutive_fails_next > error_limit);
    end
  end

  // Result word: status after this poll
  always_comb begin
    result.accepted   = check.take;
    if (check.take) begin
      result.moisture_out     = word.moisture_raw;
      result.soil_temp_out    = word.soil_temp_raw;
      result.conductivity_out = word.conductivity_raw;
      result.acidity_out      = word.acidity_raw;
      result.nitrogen_out     = word.nitrogen_raw;
      result.phosphorus_out   = word.phosphorus_raw;
      result.potassium_out    = word.potassium_raw;
    end else begin
      result.moisture_out     = held_moisture;
      result.soil_temp_out    = held_soil_temp;
      result.conductivity_out = held_conductivity;
      result.acidity_out      = held_acidity;
      result.nitrogen_out     = held_nitrogen;
      result.phosphorus_out   = held_phosphorus;
      result.potassium_out    = held_potassium;
    end
    result.healthy    = health_flag_next;
    result.run_errors = consecutive_fails_next;
    result.poll_count = total_polls_next;
    result.fail_count = total_fails_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_moisture     <= srv_pkg::MOISTURE_RESET;
      held_soil_temp    <= srv_pkg::SOIL_TEMP_RESET;
      held_conductivity <= srv_pkg::CONDUCTIVITY_RESET;
      held_acidity      <= srv_pkg::ACIDITY_RESET;
      held_nitrogen     <= srv_pkg::NUTRIENT_RESET;
      held_phosphorus   <= srv_pkg::NUTRIENT_RESET;
      held_potassium    <= srv_pkg::NUTRIENT_RESET;
      health_flag       <= 1'b0;
      consecutive_fails <= '0;
      total_polls       <= '0;
      total_fails       <= '0;
    end else if (update) begin
      held_moisture     <= result.moisture_out;
      held_soil_temp    <= result.soil_temp_out;
      held_conductivity <= result.conductivity_out;
      held_acidity      <= result.acidity_out;
      held_nitrogen     <= result.nitrogen_out;
      held_phosphorus   <= result.phosphorus_out;
      held_potassium    <= result.potassium_out;
      health_flag       <= health_flag_next;
      consecutive_fails <= consecutive_fails_next;
      total_polls       <= total_polls_next;
      total_fails       <= total_fails_next;
    end
  end

endmodule : srv_track
`default_nettype wire

// ===== hdl/soil_reading_validator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// soil_reading_validator_unit
// Validates soil-sensor poll results and keeps the last good readings.
//
// Input channel (in_valid / in_stall / in_word): one poll result per word,
// taken at an edge where in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall / out_word): one status word per
// poll, in order, with the held readings and counters after that poll.
// Configuration: cfg_write loads cfg_data into the error limit; write it
// only while no poll is in flight.
// Pipeline: a poll passes the input register, then range check and state
// update into the output register, where out_valid rises for its status
// word. Throughput is one poll per cycle while out_stall is low; the
// state update loops back through the tracker registers.
// A stalled output holds its word; the input register keeps accepting
// while it is empty or moving on, so in_stall rises only when both
// registers are full and out_stall is high.
// Reset clears both valid flags, restores the default held readings, the
// error limit of 5, a cleared health flag and zero counters.
// ----------------------------------------------------------------------------
module soil_reading_validator_unit (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire srv_pkg::in_word_t in_word,
  output logic                   out_valid,
  input  wire                    out_stall,
  output srv_pkg::out_word_t     out_word,
  input  wire                    cfg_write,
  input  wire [7:0]              cfg_data
);

  logic               stage_valid;
  srv_pkg::in_word_t  stage_word;
  logic               advance;
  logic [7:0]         error_limit;
  srv_pkg::check_t    check;
  srv_pkg::out_word_t result;

  // Handshake: stage moves on when output is empty or being taken
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;

  // Error limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit <= srv_pkg::ERROR_LIMIT_RESET;
    end else if (cfg_write) begin
      error_limit <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_word <= in_word;
    end
  end

  srv_check u_check (
    .word  (stage_word),
    .check (check)
  );

  srv_track u_track (
    .clk         (clk),
    .rst         (rst),
    .update      (advance),
    .word        (stage_word),
    .check       (check),
    .error_limit (error_limit),
    .result      (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

endmodule : soil_reading_validator_unit
`default_nettype wire
